FILE: sv/countdown_timer_pool_unit_assert.svh
// assertion macros for the countdown timer pool
// used by countdown_timer_pool_unit; no other dependencies
`ifndef COUNTDOWN_TIMER_POOL_UNIT_ASSERT_SVH
`define COUNTDOWN_TIMER_POOL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CTP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CTP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CTP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CTP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/ctp_pkg.sv
// shared types and codes for the countdown timer pool
// no dependencies
package ctp_pkg;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [2:0] STAT_ADDED     = 3'd0;
   localparam logic [2:0] STAT_FULL      = 3'd1;
   localparam logic [2:0] STAT_CANCELLED = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_EXPIRED   = 3'd4;
   localparam logic [2:0] STAT_TICK_DONE = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] delay;
      logic [7:0]  action;
      logic [31:0] tag;
      logic [3:0]  handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [7:0]  fired_action;
      logic [31:0] fired_tag;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

endpackage

FILE: sv/ctp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ctp_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/ctp_slot_find.sv
// lowest free slot search over the armed vector
// no dependencies
module ctp_slot_find #(
   parameter int SLOTS = 16
) (
   input  logic [SLOTS-1:0]         armed,
   output logic                     found,
   output logic [$clog2(SLOTS)-1:0] idx
);
   always_comb begin
      found = 1'b0;
      idx   = '0;
      // walk downward so the lowest free slot wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!armed[i]) begin
            found = 1'b1;
            idx   = ($clog2(SLOTS))'(i);
         end
      end
   end
endmodule

FILE: sv/countdown_timer_pool_unit.sv
// countdown timer pool top level: command decode, tick scan and result register
// depends on ctp_pkg, ctp_ram, ctp_slot_find and countdown_timer_pool_unit_assert.svh

// A pool of TIMER_SLOTS one-shot timers. A transaction is taken when start is high
// and busy is low. For add and cancel the result strobes on rsp_valid in the next
// cycle, and a new transaction may be taken in that same cycle. A tick walks the
// timer memory one slot per cycle (one read and one write-back per slot) while busy
// stays high; expiry results strobe as slots reach zero, in ascending slot order,
// and the tick-done result with last set comes out in the cycle busy drops. Results
// are shown for exactly one cycle and must be captured then; there is no way to
// hold them off.
module countdown_timer_pool_unit #(
   parameter int TIMER_SLOTS = 16,
   parameter int DELAY_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ctp_pkg::req_type req_data,
   output logic             rsp_valid,
   output ctp_pkg::rsp_type rsp_data
);
   import ctp_pkg::*;
   `include "countdown_timer_pool_unit_assert.svh"

   localparam int SLOT_BITS  = $clog2(TIMER_SLOTS);
   localparam int ENTRY_BITS = DELAY_BITS + 40;

   state_type              state_ff, state_in;
   logic [TIMER_SLOTS-1:0] armed_ff, armed_in;
   logic [SLOT_BITS-1:0]   scan_ff, scan_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [SLOT_BITS-1:0]   pend_idx_ff, pend_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic [SLOT_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0]  wr_data;
   logic                   rd_en;
   logic [SLOT_BITS-1:0]   rd_addr;
   logic [ENTRY_BITS-1:0]  rd_data;

   logic                   free_found;
   logic [SLOT_BITS-1:0]   free_idx;
   logic                   accept;
   logic [DELAY_BITS-1:0]  add_ticks;
   logic                   hdl_in_range;
   logic [SLOT_BITS-1:0]   hdl_idx;
   logic [DELAY_BITS-1:0]  ent_ticks;
   logic [7:0]             ent_action;
   logic [31:0]            ent_tag;
   logic [DELAY_BITS-1:0]  ent_dec;

   ctp_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(TIMER_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   ctp_slot_find #(
      .SLOTS(TIMER_SLOTS)
   ) u_find (
      .armed(armed_ff),
      .found(free_found),
      .idx  (free_idx)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // delay is masked to the counter width, zero is taken as one tick
   assign add_ticks = (DELAY_BITS'(req_data.delay) == '0) ? DELAY_BITS'(1)
                                                          : DELAY_BITS'(req_data.delay);

   assign hdl_in_range = (32'(req_data.handle) < 32'(TIMER_SLOTS));
   assign hdl_idx      = SLOT_BITS'(req_data.handle);

   // entry layout: ticks, action, tag
   assign ent_ticks  = rd_data[ENTRY_BITS-1 -: DELAY_BITS];
   assign ent_action = rd_data[39:32];
   assign ent_tag    = rd_data[31:0];
   assign ent_dec    = ent_ticks - DELAY_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      armed_in     = armed_ff;
      scan_in      = scan_ff;
      pend_vld_in  = 1'b0;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = scan_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                     if (free_found) begin
                        armed_in[free_idx] = 1'b1;
                        wr_en              = 1'b1;
                        wr_addr            = free_idx;
                        wr_data            = {add_ticks, req_data.action, req_data.tag};
                        rsp_in.status      = STAT_ADDED;
                        rsp_in.slot        = 4'(free_idx);
                     end else begin
                        rsp_in.status = STAT_FULL;
                     end
                  end
                  KIND_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                     rsp_in.slot  = req_data.handle;
                     if (hdl_in_range && armed_ff[hdl_idx]) begin
                        armed_in[hdl_idx] = 1'b0;
                        rsp_in.status     = STAT_CANCELLED;
                     end else begin
                        rsp_in.status = STAT_NOT_FOUND;
                     end
                  end
                  KIND_TICK: begin
                     state_in = S_SCAN;
                     scan_in  = '0;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_en       = 1'b1;
            pend_vld_in = 1'b1;
            pend_idx_in = scan_ff;
            if (scan_ff == SLOT_BITS'(TIMER_SLOTS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               scan_in = scan_ff + SLOT_BITS'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = STAT_TICK_DONE;
            rsp_in.last   = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // read data of the previous scan slot is back: count down and write back
      if (pend_vld_ff && armed_ff[pend_idx_ff]) begin
         wr_en   = 1'b1;
         wr_addr = pend_idx_ff;
         wr_data = {ent_dec, ent_action, ent_tag};
         if (ent_dec == '0) begin
            armed_in[pend_idx_ff] = 1'b0;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = STAT_EXPIRED;
            rsp_in.slot           = 4'(pend_idx_ff);
            rsp_in.fired_action   = ent_action;
            rsp_in.fired_tag      = ent_tag;
            rsp_in.last           = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         armed_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   `CTP_ASSERT_IMP(a_only_expiry_not_last, clock, reset, rsp_valid && !rsp_data.last, rsp_data.status == STAT_EXPIRED, "non-final result is not an expiry")
   `CTP_ASSERT_NXT(a_tick_goes_busy, clock, reset, accept && req_data.kind == KIND_TICK, busy, "tick transaction did not start a scan")
   `CTP_ASSERT_IMP(a_no_pending_idle, clock, reset, state_ff == S_IDLE, !pend_vld_ff, "scan write-back pending while idle")
   `CTP_ASSERT_IMP(a_done_on_release, clock, reset, $fell(busy) && !$past(reset), rsp_valid && rsp_data.status == STAT_TICK_DONE && rsp_data.last, "busy dropped without tick done")
endmodule
